/* hw/rtl/polyphonic_voice_allocator_core_macros.svh */
// assertion macros for the voice allocator
// used by polyphonic_voice_allocator_core, expects clock and reset in scope
`ifndef POLYPHONIC_VOICE_ALLOCATOR_CORE_MACROS_SVH
`define POLYPHONIC_VOICE_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication
`define PVA_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("voice allocator check failed");

// next-cycle implication
`define PVA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("voice allocator check failed");

`endif

/* hw/rtl/pva_pkg.sv */
// shared types and constants for the voice allocator
// used by pva_cell and polyphonic_voice_allocator_core, no dependencies
package pva_pkg;

   localparam int MAX_VOICES  = 64;
   localparam int IDX_W       = 6;
   localparam int NOTE_W      = 7;
   localparam int LEVEL_W_MAX = 16;
   localparam int CNT_W       = 7;
   localparam int FIN_W       = 4;
   localparam int VOICE_W     = 4;
   localparam int MASK_W      = 16;
   localparam int OUT_CNT_W   = 5;
   localparam int OUT_CNT_MAX = (1 << OUT_CNT_W) - 1;
   localparam int CMD_W       = 2;
   localparam int ACT_W       = 3;

   typedef enum logic [CMD_W-1:0] {
      CMD_NOTE_ON,
      CMD_NOTE_OFF,
      CMD_ALL_OFF,
      CMD_FINISHED
   } cmd_type;

   typedef enum logic [ACT_W-1:0] {
      ACT_UPDATED,
      ACT_STARTED,
      ACT_STOLEN,
      ACT_RELEASE,
      ACT_NOMATCH,
      ACT_FREED
   } action_type;

   typedef enum logic [1:0] {
      CM_NONE,
      CM_START,
      CM_UPDATE,
      CM_FREE
   } commit_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT
   } state_type;

   // record carried down the cell chain
   typedef struct packed {
      logic                   match_found;
      logic [IDX_W-1:0]       match_idx;
      logic                   free_found;
      logic [IDX_W-1:0]       free_idx;
      logic [IDX_W-1:0]       free_rank;
      logic [IDX_W-1:0]       oldest_idx;
      logic [NOTE_W-1:0]      oldest_note;
      logic [MASK_W-1:0]      mask;
      logic [CNT_W-1:0]       count;
      logic                   fin_active;
      logic [LEVEL_W_MAX-1:0] fin_level;
   } scan_type;

   // state update broadcast to every cell
   typedef struct packed {
      commit_kind_type        kind;
      logic [IDX_W-1:0]       idx;
      logic [IDX_W-1:0]       rank;
      logic [NOTE_W-1:0]      note;
      logic [LEVEL_W_MAX-1:0] level;
   } commit_type;

endpackage

/* hw/rtl/pva_cell.sv */
// one voice slot: holds active, note, level and age rank of a voice
// merges its state into the scan record and registers it for the next cell; uses pva_pkg
module pva_cell #(
   parameter int CELL_IDX      = 0,
   parameter int NUM_VOICES    = 16,
   parameter int VELOCITY_BITS = 11
) (
   input  logic               clock,
   input  logic               reset,
   input  pva_pkg::scan_type   scan_in,
   output pva_pkg::scan_type   scan_out,
   input  pva_pkg::cmd_type    req_cmd,
   input  logic [pva_pkg::NOTE_W-1:0] req_note,
   input  logic [pva_pkg::FIN_W-1:0]  req_fin,
   input  pva_pkg::commit_type commit
);
   import pva_pkg::*;

   localparam int RANK_W   = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
   localparam int MASK_BIT = CELL_IDX % MASK_W;

   logic                     active_ff, active_in;
   logic [NOTE_W-1:0]        note_ff, note_in;
   logic [VELOCITY_BITS-1:0] level_ff, level_in;
   logic [RANK_W-1:0]        rank_ff, rank_in;
   scan_type                 scan_ff, scan_in_d;
   logic                     is_pick;
   logic                     note_hit;

   assign is_pick  = (commit.idx == IDX_W'(CELL_IDX));
   assign note_hit = (note_ff == req_note);

   always_comb begin
      active_in = active_ff;
      note_in   = note_ff;
      level_in  = level_ff;
      rank_in   = rank_ff;
      case (commit.kind)
         CM_START: begin
            if (is_pick) begin
               active_in = 1'b1;
               note_in   = commit.note;
               level_in  = commit.level[VELOCITY_BITS-1:0];
               rank_in   = RANK_W'(NUM_VOICES - 1);
            end else if (IDX_W'(rank_ff) > commit.rank) begin
               rank_in = rank_ff - RANK_W'(1);
            end
         end
         CM_UPDATE: begin
            if (is_pick) begin
               level_in = commit.level[VELOCITY_BITS-1:0];
            end
         end
         CM_FREE: begin
            if (is_pick) begin
               active_in = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      scan_in_d       = scan_in;
      scan_in_d.count = scan_in.count + CNT_W'(active_ff);
      if (active_ff && note_hit && !scan_in.match_found) begin
         scan_in_d.match_found = 1'b1;
         scan_in_d.match_idx   = IDX_W'(CELL_IDX);
      end
      if (!active_ff && !scan_in.free_found) begin
         scan_in_d.free_found = 1'b1;
         scan_in_d.free_idx   = IDX_W'(CELL_IDX);
         scan_in_d.free_rank  = IDX_W'(rank_ff);
      end
      if (rank_ff == '0) begin
         scan_in_d.oldest_idx  = IDX_W'(CELL_IDX);
         scan_in_d.oldest_note = note_ff;
      end
      if (CELL_IDX < MASK_W && active_ff && (req_cmd == CMD_ALL_OFF || note_hit)) begin
         scan_in_d.mask[MASK_BIT] = 1'b1;
      end
      if (IDX_W'(req_fin) == IDX_W'(CELL_IDX)) begin
         scan_in_d.fin_active = active_ff;
         scan_in_d.fin_level  = LEVEL_W_MAX'(level_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         note_ff   <= '0;
         level_ff  <= '0;
         rank_ff   <= RANK_W'(CELL_IDX);
      end else begin
         active_ff <= active_in;
         note_ff   <= note_in;
         level_ff  <= level_in;
         rank_ff   <= rank_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in_d;
   end

   assign scan_out = scan_ff;

endmodule

/* hw/rtl/polyphonic_voice_allocator_core.sv */
// voice allocator top level: request/response control and the chain of voice cells
// depends on pva_pkg, pva_cell and polyphonic_voice_allocator_core_macros.svh
//
// usage
//   req channel: one request per note event; command in req_tuser, note, velocity and
//   finished voice in req_tdata. rsp channel: exactly one response per request, action
//   in rsp_tuser, voice, velocity, stolen note, release mask and active count in rsp_tdata.
//   csr_wr_en/csr_wr_data set the retrigger enable; write it only while no request is open.
//   a request walks the voice cells one per cycle, so the scan time is set by the length
//   of the cell chain; then the commit state updates every voice at once and loads the
//   response register. a new request is taken only after the previous one has committed,
//   and req_tready is high only between requests.
//   the next request may be taken while a response still waits in the output register;
//   if rsp_tready is low, that request holds in its commit cycle until the response
//   register frees, and no voice state changes meanwhile.
//   reset: all voices inactive with note and level zero, age ranks equal to voice index,
//   retrigger enabled, no response pending. no clearing pass is needed.
`include "polyphonic_voice_allocator_core_macros.svh"

module polyphonic_voice_allocator_core #(
   parameter int NUM_VOICES    = 16,
   parameter int VELOCITY_BITS = 11,
   localparam int REQ_DATA_W =
      ((pva_pkg::NOTE_W + VELOCITY_BITS + pva_pkg::FIN_W + 7) / 8) * 8,
   localparam int RSP_DATA_W = ((pva_pkg::VOICE_W + VELOCITY_BITS + pva_pkg::NOTE_W
      + pva_pkg::MASK_W + pva_pkg::OUT_CNT_W + 7) / 8) * 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [REQ_DATA_W-1:0]       req_tdata,   // note, velocity, finished_voice
   input  logic [pva_pkg::CMD_W-1:0]   req_tuser,   // command
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [RSP_DATA_W-1:0]       rsp_tdata,   // voice, voice_velocity, stolen_note,
                                                    // release_mask, active_count
   output logic [pva_pkg::ACT_W-1:0]   rsp_tuser,   // action
   input  logic                        csr_wr_en,
   input  logic                        csr_wr_data
);
   import pva_pkg::*;

   localparam int VB        = VELOCITY_BITS;
   localparam int STEP_W    = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
   localparam int VEL_ONE_I = 1 << (VELOCITY_BITS - 1);
   localparam int VEL_MIN_I = (VEL_ONE_I * 5) / 100;
   localparam int FULL_I    = (NUM_VOICES > OUT_CNT_MAX) ? OUT_CNT_MAX : NUM_VOICES;
   localparam logic [VB-1:0]        VEL_ONE  = VB'(VEL_ONE_I);
   localparam logic [VB-1:0]        VEL_MIN  = VB'(VEL_MIN_I);
   localparam logic [OUT_CNT_W-1:0] CNT_FULL = OUT_CNT_W'(FULL_I);

   state_type               state_ff, state_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   cmd_type                 cmd_ff;
   logic [NOTE_W-1:0]       note_ff;
   logic [VB-1:0]           vel_ff;
   logic [FIN_W-1:0]        fin_ff;
   logic                    retrig_ff;
   logic                    req_fire;
   logic                    commit_fire;

   logic [NOTE_W-1:0]       req_note;
   logic [VB-1:0]           req_vel;
   logic [FIN_W-1:0]        req_fin;
   logic [VB-1:0]           vel_clamped;

   scan_type                chain_in  [NUM_VOICES];
   scan_type                chain_out [NUM_VOICES];
   scan_type                last;
   commit_type              commit_d, commit_bus;

   action_type              act_d;
   logic [IDX_W-1:0]        idx_d;
   logic [VB-1:0]           vvel_d;
   logic [NOTE_W-1:0]       stolen_d;
   logic [MASK_W-1:0]       mask_d;
   logic [CNT_W-1:0]        cnt_after;
   logic [OUT_CNT_W-1:0]    cnt_sat;

   logic                    rsp_valid_ff, rsp_valid_in;
   action_type              rsp_act_ff;
   logic [VOICE_W-1:0]      rsp_voice_ff;
   logic [VB-1:0]           rsp_vel_ff;
   logic [NOTE_W-1:0]       rsp_stolen_ff;
   logic [MASK_W-1:0]       rsp_mask_ff;
   logic [OUT_CNT_W-1:0]    rsp_cnt_ff;

   assign req_note = req_tdata[NOTE_W-1:0];
   assign req_vel  = req_tdata[NOTE_W+VB-1:NOTE_W];
   assign req_fin  = req_tdata[NOTE_W+VB+FIN_W-1:NOTE_W+VB];

   assign vel_clamped = (req_vel < VEL_MIN) ? VEL_MIN :
                        (req_vel > VEL_ONE) ? VEL_ONE : req_vel;

   // control
   always_comb begin
      state_in    = state_ff;
      step_in     = step_ff;
      req_tready  = 1'b0;
      commit_fire = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = ST_SCAN;
               step_in  = '0;
            end
         end
         ST_SCAN: begin
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(NUM_VOICES - 1)) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               commit_fire = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_fire = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         retrig_ff    <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            retrig_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff  <= cmd_type'(req_tuser);
         note_ff <= req_note;
         vel_ff  <= vel_clamped;
         fin_ff  <= req_fin;
      end
   end

   // cell chain
   for (genvar g = 0; g < NUM_VOICES; g++) begin : g_cell
      if (g == 0) begin : g_head
         assign chain_in[g] = scan_type'('0);
      end else begin : g_link
         assign chain_in[g] = chain_out[g-1];
      end
      pva_cell #(
         .CELL_IDX      (g),
         .NUM_VOICES    (NUM_VOICES),
         .VELOCITY_BITS (VELOCITY_BITS)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .scan_in  (chain_in[g]),
         .scan_out (chain_out[g]),
         .req_cmd  (cmd_ff),
         .req_note (note_ff),
         .req_fin  (fin_ff),
         .commit   (commit_bus)
      );
   end

   assign last = chain_out[NUM_VOICES-1];

   // decision on the finished scan
   always_comb begin
      act_d          = ACT_NOMATCH;
      idx_d          = '0;
      vvel_d         = '0;
      stolen_d       = '0;
      mask_d         = '0;
      cnt_after      = last.count;
      commit_d       = commit_type'('0);
      commit_d.kind  = CM_NONE;
      commit_d.note  = note_ff;
      commit_d.level = LEVEL_W_MAX'(vel_ff);
      case (cmd_ff)
         CMD_NOTE_ON: begin
            vvel_d = vel_ff;
            if (!retrig_ff && last.match_found) begin
               act_d         = ACT_UPDATED;
               idx_d         = last.match_idx;
               commit_d.kind = CM_UPDATE;
            end else if (last.free_found) begin
               act_d         = ACT_STARTED;
               idx_d         = last.free_idx;
               commit_d.kind = CM_START;
               commit_d.rank = last.free_rank;
               cnt_after     = last.count + CNT_W'(1);
            end else begin
               act_d         = ACT_STOLEN;
               idx_d         = last.oldest_idx;
               stolen_d      = last.oldest_note;
               commit_d.kind = CM_START;
               commit_d.rank = '0;
            end
         end
         CMD_NOTE_OFF, CMD_ALL_OFF: begin
            mask_d = last.mask;
            act_d  = (last.mask != '0) ? ACT_RELEASE : ACT_NOMATCH;
         end
         CMD_FINISHED: begin
            if (last.fin_active) begin
               act_d         = ACT_FREED;
               idx_d         = IDX_W'(fin_ff);
               vvel_d        = last.fin_level[VB-1:0];
               commit_d.kind = CM_FREE;
               cnt_after     = last.count - CNT_W'(1);
            end
         end
         default: ;
      endcase
      commit_d.idx = idx_d;
   end

   assign cnt_sat = (cnt_after > CNT_W'(OUT_CNT_MAX)) ? OUT_CNT_W'(OUT_CNT_MAX)
                                                     : cnt_after[OUT_CNT_W-1:0];

   always_comb begin
      commit_bus = commit_d;
      if (!commit_fire) begin
         commit_bus.kind = CM_NONE;
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit_fire) begin
         rsp_act_ff    <= act_d;
         rsp_voice_ff  <= idx_d[VOICE_W-1:0];
         rsp_vel_ff    <= vvel_d;
         rsp_stolen_ff <= stolen_d;
         rsp_mask_ff   <= mask_d;
         rsp_cnt_ff    <= cnt_sat;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_act_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_cnt_ff, rsp_mask_ff, rsp_stolen_ff,
                                   rsp_vel_ff, rsp_voice_ff});

   `PVA_ASSERT_NEXT(a_accept_starts_scan, req_fire, state_ff == ST_SCAN)
   `PVA_ASSERT_NEXT(a_commit_loads_rsp, commit_fire, rsp_valid_ff && state_ff == ST_IDLE)
   `PVA_ASSERT_IMPL(a_release_has_mask, rsp_valid_ff && rsp_act_ff == ACT_RELEASE, rsp_mask_ff != '0)
   `PVA_ASSERT_IMPL(a_steal_only_when_full, rsp_valid_ff && rsp_act_ff == ACT_STOLEN, rsp_cnt_ff == CNT_FULL)

endmodule
